>>> rtl/core/mmc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the motor mix controller.
package mmc_pkg;

	// Working width of the control arithmetic; everything wraps at this width.
	localparam int DATA_W = 32;

	typedef logic [DATA_W-1:0] word_t;

	// Flight mode codes carried on the mode field.
	localparam logic [3:0] MODE_SAFE        = 4'd0;
	localparam logic [3:0] MODE_PANIC_ENTRY = 4'd1;
	localparam logic [3:0] MODE_PANIC       = 4'd2;
	localparam logic [3:0] MODE_MANUAL      = 4'd3;
	localparam logic [3:0] MODE_CALIB       = 4'd4;
	localparam logic [3:0] MODE_YAW         = 4'd5;
	localparam logic [3:0] MODE_FULL        = 4'd6;
	localparam logic [3:0] MODE_HEIGHT      = 4'd7;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PANIC_STEP  = 3'd4;

	// Lift below this level switches every motor off in the mixing modes.
	localparam logic [15:0] LOW_LIFT_LIMIT = 16'd100;

	localparam int MOTOR_COUNT = 4;
	localparam int MOTOR_IDX_W = $clog2(MOTOR_COUNT);

	// Reciprocal shifts reach DATA_W plus the bits of the largest motor divider.
	localparam int SHIFT_W = 6;

	// Request to the shared divider and its answer.
	typedef struct packed {
		logic                start;
		word_t               dividend;
		logic [DATA_W:0]     magic;
		logic [SHIFT_W-1:0]  shift;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t quotient;
	} div_rsp_t;

endpackage

>>> rtl/core/mmc_div.sv
`timescale 1ns / 1ps
// Shared divider by a constant, using a reciprocal product built from two partial products.
module mmc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mmc_pkg::div_req_t req,
	output mmc_pkg::div_rsp_t rsp
);

	localparam int LO_W   = 16;
	localparam int HI_W   = mmc_pkg::DATA_W + 1 - LO_W;
	localparam int PROD_W = mmc_pkg::DATA_W + HI_W;
	localparam int ACC_W  = PROD_W + LO_W;

	logic                          hi_q;
	logic                          lo_q;
	logic                          done_q;
	mmc_pkg::word_t                x_q;
	logic [mmc_pkg::DATA_W:0]      magic_q;
	logic [mmc_pkg::SHIFT_W-1:0]   shift_q;
	logic [ACC_W-1:0]              acc_q;
	logic [HI_W-1:0]               part;
	logic [PROD_W-1:0]             prod;
	logic [ACC_W-1:0]              acc_sh;

	// One partial product a cycle: the upper magic bits first, then the lower ones.
	always_comb begin
		part   = hi_q ? magic_q[mmc_pkg::DATA_W:LO_W] : HI_W'(magic_q[LO_W-1:0]);
		prod   = PROD_W'(x_q) * PROD_W'(part);
		acc_sh = acc_q >> shift_q;
	end

	// Phase control: upper product, lower product, then the quotient is ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q   <= 1'b0;
			lo_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			hi_q   <= req.start;
			lo_q   <= hi_q;
			done_q <= lo_q;
		end
	end

	// Operands and the accumulated product.
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q     <= req.dividend;
			magic_q <= req.magic;
			shift_q <= req.shift;
		end
		if (hi_q) begin
			acc_q <= ACC_W'(prod);
		end else if (lo_q) begin
			acc_q <= {acc_q[PROD_W-1:0], {LO_W{1'b0}}} + ACC_W'(prod);
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = acc_sh[mmc_pkg::DATA_W-1:0];

endmodule

>>> rtl/core/motor_mix_controller_core.sv
`timescale 1ns / 1ps
// Top level of the motor mix controller: sequencer, shared multiplier and mixer.
//
// Channel   Direction  Handshake               Contents
// in        request    in_valid / in_stall     mode, setpoints, measurements
// out       result     out_valid / out_stall   four motor drive values
// cfg       write      cfg_wr_en               gains and panic step
//
// A mixing mode runs six steps on the shared 8 x 32 multiplier, four command scalings on the
// reciprocal divider, four motor scalings including the mixer, and an output step. The next
// request is taken once the sequencer is back in idle. Panic modes pass a panic step before
// the output step; safe and calibration go straight to it. Only one request is in work.
// Reset clears the gains to their defaults and the stored motor values to zero.
// A stalled result holds in the output register; the next request is still taken.
module motor_mix_controller_core #(
	parameter int LIFT_DIVISOR  = 4,
	parameter int TILT_DIVISOR  = 8,
	parameter int YAW_DIVISOR   = 8,
	parameter int MIX_CLAMP     = 16384,
	parameter int MOTOR_FLOOR   = 256,
	parameter int MOTOR_CEILING = 1000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [3:0]                          mode,
	input  logic [15:0]                         target_lift,
	input  logic signed [15:0]                  target_roll,
	input  logic signed [15:0]                  target_pitch,
	input  logic signed [15:0]                  target_yaw,
	input  logic signed [15:0]                  measured_roll,
	input  logic signed [15:0]                  measured_pitch,
	input  logic signed [15:0]                  measured_yaw,
	input  logic signed [15:0]                  pressure_setpoint,
	input  logic signed [15:0]                  measured_pressure,
	input  logic signed [15:0]                  roll_rate,
	input  logic signed [15:0]                  pitch_rate,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [15:0]                         motor_front,
	output logic [15:0]                         motor_right,
	output logic [15:0]                         motor_back,
	output logic [15:0]                         motor_left
);

	// Divisors, guarded against zero, and the motor scaling divider.
	localparam int LIFT_DIV  = (LIFT_DIVISOR  == 0) ? 1 : LIFT_DIVISOR;
	localparam int TILT_DIV  = (TILT_DIVISOR  == 0) ? 1 : TILT_DIVISOR;
	localparam int YAW_DIV   = (YAW_DIVISOR   == 0) ? 1 : YAW_DIVISOR;
	localparam int MOTOR_SPAN = (MOTOR_CEILING > MOTOR_FLOOR) ? (MOTOR_CEILING - MOTOR_FLOOR) : 1;
	localparam int MOTOR_DIV_RAW = MIX_CLAMP / MOTOR_SPAN;
	localparam int MOTOR_DIV = (MOTOR_DIV_RAW == 0) ? 1 : MOTOR_DIV_RAW;
	localparam int CLAMP_W = $clog2(MIX_CLAMP + 1);

	// Reciprocals of the divisors: for any 32-bit x, x / d is (x * magic) >> shift.
	// The magic value is rounded up, which keeps every quotient exact.
	localparam int LIFT_SHIFT_N  = mmc_pkg::DATA_W + $clog2(LIFT_DIV);
	localparam int TILT_SHIFT_N  = mmc_pkg::DATA_W + $clog2(TILT_DIV);
	localparam int YAW_SHIFT_N   = mmc_pkg::DATA_W + $clog2(YAW_DIV);
	localparam int MOTOR_SHIFT_N = mmc_pkg::DATA_W + $clog2(MOTOR_DIV);
	localparam logic [mmc_pkg::DATA_W:0] LIFT_MAGIC = (mmc_pkg::DATA_W + 1)'(
		((64'd1 << LIFT_SHIFT_N) + 64'(LIFT_DIV - 1)) / 64'(LIFT_DIV));
	localparam logic [mmc_pkg::DATA_W:0] TILT_MAGIC = (mmc_pkg::DATA_W + 1)'(
		((64'd1 << TILT_SHIFT_N) + 64'(TILT_DIV - 1)) / 64'(TILT_DIV));
	localparam logic [mmc_pkg::DATA_W:0] YAW_MAGIC = (mmc_pkg::DATA_W + 1)'(
		((64'd1 << YAW_SHIFT_N) + 64'(YAW_DIV - 1)) / 64'(YAW_DIV));
	localparam logic [mmc_pkg::DATA_W:0] MOTOR_MAGIC = (mmc_pkg::DATA_W + 1)'(
		((64'd1 << MOTOR_SHIFT_N) + 64'(MOTOR_DIV - 1)) / 64'(MOTOR_DIV));
	localparam logic [mmc_pkg::SHIFT_W-1:0] LIFT_SHIFT  = (mmc_pkg::SHIFT_W)'(LIFT_SHIFT_N);
	localparam logic [mmc_pkg::SHIFT_W-1:0] TILT_SHIFT  = (mmc_pkg::SHIFT_W)'(TILT_SHIFT_N);
	localparam logic [mmc_pkg::SHIFT_W-1:0] YAW_SHIFT   = (mmc_pkg::SHIFT_W)'(YAW_SHIFT_N);
	localparam logic [mmc_pkg::SHIFT_W-1:0] MOTOR_SHIFT = (mmc_pkg::SHIFT_W)'(MOTOR_SHIFT_N);

	// Multiplier steps.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_YAW        = 3'd0;
	localparam logic [STEP_W-1:0] STEP_ROLL_ANGLE = 3'd1;
	localparam logic [STEP_W-1:0] STEP_PITCH_ANG  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_ROLL_RATE  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_PITCH_RATE = 3'd4;
	localparam logic [STEP_W-1:0] STEP_HEIGHT     = 3'd5;

	// Command slots; the same index walks the motors during mixing.
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] CMD_LIFT  = 2'd0;
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] CMD_ROLL  = 2'd1;
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] CMD_PITCH = 2'd2;
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] CMD_YAW   = 2'd3;
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] M_FRONT   = 2'd0;
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] M_RIGHT   = 2'd1;
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] M_BACK    = 2'd2;
	localparam logic [mmc_pkg::MOTOR_IDX_W-1:0] M_LAST    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SDIV_GO,
		ST_SDIV_WAIT,
		ST_MIX,
		ST_MDIV_GO,
		ST_MDIV_WAIT,
		ST_PANIC,
		ST_OUT
	} state_t;

	state_t                              state_q;
	logic [STEP_W-1:0]                   step_q;
	logic [mmc_pkg::MOTOR_IDX_W-1:0]     idx_q;
	logic                                out_valid_q;
	logic [15:0]                         out_front_q;
	logic [15:0]                         out_right_q;
	logic [15:0]                         out_back_q;
	logic [15:0]                         out_left_q;
	logic [15:0]                         motor_q [mmc_pkg::MOTOR_COUNT];

	logic [7:0]                          yaw_gain_q;
	logic [7:0]                          height_gain_q;
	logic [7:0]                          angle_gain_q;
	logic [7:0]                          rate_gain_q;
	logic [7:0]                          panic_step_q;

	logic [3:0]                          mode_q;
	logic [15:0]                         t_lift_q;
	logic signed [15:0]                  t_roll_q;
	logic signed [15:0]                  t_pitch_q;
	logic signed [15:0]                  t_yaw_q;
	logic signed [15:0]                  m_roll_q;
	logic signed [15:0]                  m_pitch_q;
	logic signed [15:0]                  m_yaw_q;
	logic signed [15:0]                  p_set_q;
	logic signed [15:0]                  p_meas_q;
	logic signed [15:0]                  r_rate_q;
	logic signed [15:0]                  p_rate_q;
	mmc_pkg::word_t                      cmd_q [mmc_pkg::MOTOR_COUNT];
	mmc_pkg::word_t                      ps_q;
	mmc_pkg::word_t                      qs_q;
	logic [CLAMP_W-1:0]                  clamp_q;

	logic                                in_acc;
	logic                                out_acc;
	logic                                out_free;
	logic                                in_panic;
	logic                                in_off;
	logic                                mode_yaw_loop;
	logic                                mode_att_loop;

	logic [7:0]                          mul_gain;
	mmc_pkg::word_t                      mul_x;
	mmc_pkg::word_t                      mul_y;
	mmc_pkg::word_t                      mul_diff;
	logic [mmc_pkg::DATA_W+7:0]          mul_full;
	mmc_pkg::word_t                      mul_prod;

	mmc_pkg::word_t                      cmd_sel;
	mmc_pkg::word_t                      cmd_mag;
	logic [mmc_pkg::DATA_W:0]            sdiv_magic;
	logic [mmc_pkg::SHIFT_W-1:0]         sdiv_shift;
	mmc_pkg::word_t                      sdiv_result;
	mmc_pkg::word_t                      mix_sum;
	logic [CLAMP_W-1:0]                  mix_clamped;
	logic [15:0]                         motor_val;

	logic [17:0]                         avg_sum;
	logic [15:0]                         avg_val;
	logic [15:0]                         panic_base;
	logic [15:0]                         panic_ramp;

	mmc_pkg::div_req_t                   div_req;
	mmc_pkg::div_rsp_t                   div_rsp;

	// Handshakes.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_acc   = out_valid_q & ~out_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign motor_front = out_front_q;
	assign motor_right = out_right_q;
	assign motor_back  = out_back_q;
	assign motor_left  = out_left_q;

	// Mode classes of the incoming and of the held request.
	assign in_panic = (mode == mmc_pkg::MODE_PANIC_ENTRY) || (mode == mmc_pkg::MODE_PANIC);
	assign in_off   = (mode == mmc_pkg::MODE_SAFE) || (mode == mmc_pkg::MODE_CALIB);
	assign mode_att_loop = (mode_q == mmc_pkg::MODE_FULL) || (mode_q == mmc_pkg::MODE_HEIGHT);
	assign mode_yaw_loop = mode_att_loop || (mode_q == mmc_pkg::MODE_YAW);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_gain_q    <= 8'd1;
			height_gain_q <= 8'd1;
			angle_gain_q  <= 8'd1;
			rate_gain_q   <= 8'd1;
			panic_step_q  <= 8'd10;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mmc_pkg::CFG_YAW_GAIN:    yaw_gain_q    <= cfg_data;
				mmc_pkg::CFG_HEIGHT_GAIN: height_gain_q <= cfg_data;
				mmc_pkg::CFG_ANGLE_GAIN:  angle_gain_q  <= cfg_data;
				mmc_pkg::CFG_RATE_GAIN:   rate_gain_q   <= cfg_data;
				mmc_pkg::CFG_PANIC_STEP:  panic_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier: gain times a difference.
	always_comb begin
		case (step_q)
			STEP_YAW: begin
				mul_gain = yaw_gain_q;
				mul_x    = mmc_pkg::word_t'(t_yaw_q);
				mul_y    = mmc_pkg::word_t'(m_yaw_q);
			end
			STEP_ROLL_ANGLE: begin
				mul_gain = angle_gain_q;
				mul_x    = mmc_pkg::word_t'(t_roll_q);
				mul_y    = mmc_pkg::word_t'(m_roll_q);
			end
			STEP_PITCH_ANG: begin
				mul_gain = angle_gain_q;
				mul_x    = mmc_pkg::word_t'(t_pitch_q);
				mul_y    = mmc_pkg::word_t'(m_pitch_q);
			end
			STEP_ROLL_RATE: begin
				mul_gain = rate_gain_q;
				mul_x    = ps_q;
				mul_y    = mmc_pkg::word_t'(r_rate_q);
			end
			STEP_PITCH_RATE: begin
				// Operands swapped so the product is already the negated pitch command.
				mul_gain = rate_gain_q;
				mul_x    = mmc_pkg::word_t'(p_rate_q);
				mul_y    = qs_q;
			end
			default: begin
				mul_gain = height_gain_q;
				mul_x    = mmc_pkg::word_t'(p_set_q);
				mul_y    = mmc_pkg::word_t'(p_meas_q);
			end
		endcase
		mul_diff = mul_x - mul_y;
		mul_full = {{mmc_pkg::DATA_W{1'b0}}, mul_gain} * {8'd0, mul_diff};
		mul_prod = mul_full[mmc_pkg::DATA_W-1:0];
	end

	// Signed scaling of a command: divide the magnitude and restore the sign.
	always_comb begin
		cmd_sel = cmd_q[idx_q];
		cmd_mag = cmd_sel[mmc_pkg::DATA_W-1] ? (mmc_pkg::word_t'(0) - cmd_sel) : cmd_sel;
		case (idx_q)
			CMD_LIFT: begin
				sdiv_magic = LIFT_MAGIC;
				sdiv_shift = LIFT_SHIFT;
			end
			CMD_YAW: begin
				sdiv_magic = YAW_MAGIC;
				sdiv_shift = YAW_SHIFT;
			end
			default: begin
				sdiv_magic = TILT_MAGIC;
				sdiv_shift = TILT_SHIFT;
			end
		endcase
		sdiv_result = cmd_sel[mmc_pkg::DATA_W-1] ?
			(mmc_pkg::word_t'(0) - div_rsp.quotient) : div_rsp.quotient;
	end

	// Mixer for the motor at idx_q, then clamping to the mixing range.
	always_comb begin
		case (idx_q)
			M_FRONT: mix_sum = cmd_q[CMD_LIFT] + cmd_q[CMD_PITCH] - cmd_q[CMD_YAW];
			M_RIGHT: mix_sum = cmd_q[CMD_LIFT] - cmd_q[CMD_ROLL] + cmd_q[CMD_YAW];
			M_BACK:  mix_sum = cmd_q[CMD_LIFT] - cmd_q[CMD_PITCH] - cmd_q[CMD_YAW];
			default: mix_sum = cmd_q[CMD_LIFT] + cmd_q[CMD_ROLL] + cmd_q[CMD_YAW];
		endcase
		if (mix_sum[mmc_pkg::DATA_W-1]) begin
			mix_clamped = '0;
		end else if (mix_sum > mmc_pkg::word_t'(MIX_CLAMP)) begin
			mix_clamped = CLAMP_W'(MIX_CLAMP);
		end else begin
			mix_clamped = mix_sum[CLAMP_W-1:0];
		end
		if (t_lift_q < mmc_pkg::LOW_LIFT_LIMIT) begin
			motor_val = '0;
		end else begin
			motor_val = div_rsp.quotient[15:0] + 16'(MOTOR_FLOOR);
		end
	end

	// Panic ramp: optional averaging, then one step down towards zero.
	always_comb begin
		avg_sum = 18'(motor_q[0]) + 18'(motor_q[1]) + 18'(motor_q[2]) + 18'(motor_q[3]);
		avg_val = avg_sum[17:2];
		panic_base = (mode_q == mmc_pkg::MODE_PANIC_ENTRY) ? avg_val : motor_q[0];
		panic_ramp = (panic_base > {8'd0, panic_step_q}) ?
			(panic_base - {8'd0, panic_step_q}) : 16'd0;
	end

	// Requests to the shared divider.
	always_comb begin
		div_req.start    = (state_q == ST_SDIV_GO) || (state_q == ST_MDIV_GO);
		div_req.dividend = (state_q == ST_SDIV_GO) ? cmd_mag : mmc_pkg::word_t'(clamp_q);
		div_req.magic    = (state_q == ST_SDIV_GO) ? sdiv_magic : MOTOR_MAGIC;
		div_req.shift    = (state_q == ST_SDIV_GO) ? sdiv_shift : MOTOR_SHIFT;
	end

	mmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer, stored motor values and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_front_q <= '0;
			out_right_q <= '0;
			out_back_q  <= '0;
			out_left_q  <= '0;
			for (int i = 0; i < mmc_pkg::MOTOR_COUNT; i++) begin
				motor_q[i] <= '0;
			end
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_panic) begin
							state_q <= ST_PANIC;
						end else if (in_off) begin
							for (int i = 0; i < mmc_pkg::MOTOR_COUNT; i++) begin
								motor_q[i] <= '0;
							end
							state_q <= ST_OUT;
						end else begin
							step_q  <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (step_q == STEP_HEIGHT) begin
						idx_q   <= '0;
						state_q <= ST_SDIV_GO;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SDIV_GO: begin
					state_q <= ST_SDIV_WAIT;
				end
				ST_SDIV_WAIT: begin
					if (div_rsp.done) begin
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q == CMD_YAW) ? ST_MIX : ST_SDIV_GO;
					end
				end
				ST_MIX: begin
					state_q <= ST_MDIV_GO;
				end
				ST_MDIV_GO: begin
					state_q <= ST_MDIV_WAIT;
				end
				ST_MDIV_WAIT: begin
					if (div_rsp.done) begin
						motor_q[idx_q] <= motor_val;
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q == M_LAST) ? ST_OUT : ST_MIX;
					end
				end
				ST_PANIC: begin
					if (panic_base != 16'd0) begin
						for (int i = 0; i < mmc_pkg::MOTOR_COUNT; i++) begin
							motor_q[i] <= panic_ramp;
						end
					end else if (mode_q == mmc_pkg::MODE_PANIC_ENTRY) begin
						for (int i = 0; i < mmc_pkg::MOTOR_COUNT; i++) begin
							motor_q[i] <= avg_val;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_front_q <= motor_q[M_FRONT];
						out_right_q <= motor_q[M_RIGHT];
						out_back_q  <= motor_q[M_BACK];
						out_left_q  <= motor_q[M_LAST];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, loop products and scaled commands.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q    <= mode;
			t_lift_q  <= target_lift;
			t_roll_q  <= target_roll;
			t_pitch_q <= target_pitch;
			t_yaw_q   <= target_yaw;
			m_roll_q  <= measured_roll;
			m_pitch_q <= measured_pitch;
			m_yaw_q   <= measured_yaw;
			p_set_q   <= pressure_setpoint;
			p_meas_q  <= measured_pressure;
			r_rate_q  <= roll_rate;
			p_rate_q  <= pitch_rate;
			// Setpoints pass through; the loops overwrite what they control.
			if ((mode == mmc_pkg::MODE_MANUAL) || (mode == mmc_pkg::MODE_YAW) ||
			    (mode == mmc_pkg::MODE_FULL) || (mode == mmc_pkg::MODE_HEIGHT)) begin
				cmd_q[CMD_LIFT]  <= mmc_pkg::word_t'(target_lift);
				cmd_q[CMD_ROLL]  <= mmc_pkg::word_t'(target_roll);
				cmd_q[CMD_PITCH] <= mmc_pkg::word_t'(target_pitch);
				cmd_q[CMD_YAW]   <= mmc_pkg::word_t'(target_yaw);
			end else begin
				for (int i = 0; i < mmc_pkg::MOTOR_COUNT; i++) begin
					cmd_q[i] <= '0;
				end
			end
		end else begin
			case (state_q)
				ST_MUL: begin
					case (step_q)
						STEP_YAW: begin
							if (mode_yaw_loop) begin
								cmd_q[CMD_YAW] <= mul_prod;
							end
						end
						STEP_ROLL_ANGLE: ps_q <= mul_prod;
						STEP_PITCH_ANG:  qs_q <= mul_prod;
						STEP_ROLL_RATE: begin
							if (mode_att_loop) begin
								cmd_q[CMD_ROLL] <= mul_prod;
							end
						end
						STEP_PITCH_RATE: begin
							if (mode_att_loop) begin
								cmd_q[CMD_PITCH] <= mul_prod;
							end
						end
						default: begin
							if (mode_q == mmc_pkg::MODE_HEIGHT) begin
								cmd_q[CMD_LIFT] <= mul_prod;
							end
						end
					endcase
				end
				ST_SDIV_WAIT: begin
					if (div_rsp.done) begin
						cmd_q[idx_q] <= sdiv_result;
					end
				end
				ST_MIX: begin
					clamp_q <= mix_clamped;
				end
				default: ;
			endcase
		end
	end

endmodule
